>>> rtl/core/vmac_bt_pkg.sv
package vmac_bt_pkg;

    localparam int TableDepth = 64;
    localparam int AddrW      = 6;
    localparam int CountW     = 7;
    localparam int IdW        = 23;
    localparam int SeedW      = 22;
    localparam int MacW       = 64;
    localparam int EpW        = 8;
    localparam int EntryW     = IdW + MacW + EpW;

    localparam logic [IdW-1:0] RandomId = 23'd4194303;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_DELETE = 3'd1,
        OP_LK_ID  = 3'd2,
        OP_LK_MAC = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAW,
        ST_CHK_RAND,
        ST_SCAN_MAC,
        ST_SCAN_ID,
        ST_REMOVE,
        ST_INS_POS,
        ST_INS_SHIFT,
        ST_WRITE,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [IdW-1:0]  id;
        logic [MacW-1:0] mac;
        logic [EpW-1:0]  ep;
    } entry_t;

    // one step of the x^22 + x^21 + 1 generator
    function automatic logic [SeedW-1:0] lfsr_step(input logic [SeedW-1:0] s);
        lfsr_step = {s[SeedW-2:0], s[SeedW-1] ^ s[SeedW-2]};
    endfunction

endpackage

>>> rtl/core/vmac_bt_ram.sv
module vmac_bt_ram (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [vmac_bt_pkg::AddrW-1:0] waddr,
    input  vmac_bt_pkg::entry_t        wdata,
    input  logic [vmac_bt_pkg::AddrW-1:0] raddr,
    output vmac_bt_pkg::entry_t        rdata
);

    vmac_bt_pkg::entry_t mem [vmac_bt_pkg::TableDepth];

    // single write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/vmac_binding_table_unit.sv
// device id to mac binding table, sorted by id, 64 entries
//
// input channel s_*: one operation per transfer (add, delete, lookup by id,
// lookup by mac, read by index). result channel m_*: exactly one result per
// operation. s_ready is high only while the block is idle and no result is
// pending, so one operation is in flight at a time.
//
// scans walk the entry memory one slot at a time through a single
// registered read port and one comparator; read by index reads one slot.
// delete and add also shift the tail of the table one slot at a time.
// a random add repeats an id scan per draw, up to 65 draws.
//
// reset (aresetn low, synchronous) empties the table and loads the random
// generator with 1. cfg_we loads the seed (zero loads as 1); write it only
// while idle. a stalled result holds in m_* until m_ready, and no new
// operation is taken meanwhile.
module vmac_binding_table_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [21:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [22:0] s_device_id,
    input  logic [63:0] s_mac,
    input  logic [7:0]  s_endpoint,
    input  logic [5:0]  s_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [22:0] m_found_id,
    output logic [63:0] m_found_mac,
    output logic [7:0]  m_found_endpoint,
    output logic [6:0]  m_entries_used
);

    localparam int AW = vmac_bt_pkg::AddrW;
    localparam int CW = vmac_bt_pkg::CountW;

    vmac_bt_pkg::state_t state_reg, state_next;

    logic [2:0]  op_reg;
    logic [22:0] id_reg;
    logic [63:0] mac_reg;
    logic [7:0]  ep_reg;
    logic [5:0]  idx_reg;
    logic [21:0] rnd_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] draws_reg;
    logic        phase_reg;
    logic        ok_reg;
    logic        mval_reg;
    logic        ins_reg;
    vmac_bt_pkg::entry_t hold_reg;
    vmac_bt_pkg::entry_t res_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    vmac_bt_pkg::entry_t wdata, rdata;

    vmac_bt_ram u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic id_hit, mac_hit, id_less;
    assign id_hit  = (rdata.id == id_reg);
    assign mac_hit = (rdata.mac == mac_reg) && (rdata.ep == ep_reg);
    assign id_less = (rdata.id < id_reg);

    // phase 0 issues the read of ptr, phase 1 sees data
    logic in_range;
    assign in_range = (ptr_reg < count_reg);

    assign s_ready = (state_reg == vmac_bt_pkg::ST_IDLE) && !mval_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            vmac_bt_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    unique case (s_opcode)
                        vmac_bt_pkg::OP_ADD: state_next =
                            (s_device_id == vmac_bt_pkg::RandomId) ?
                            vmac_bt_pkg::ST_DRAW : vmac_bt_pkg::ST_SCAN_MAC;
                        vmac_bt_pkg::OP_DELETE, vmac_bt_pkg::OP_LK_ID:
                            state_next = vmac_bt_pkg::ST_SCAN_ID;
                        vmac_bt_pkg::OP_LK_MAC: state_next = vmac_bt_pkg::ST_SCAN_MAC;
                        vmac_bt_pkg::OP_READ: state_next = vmac_bt_pkg::ST_READ;
                        default: state_next = vmac_bt_pkg::ST_DONE;
                    endcase
                end
            end
            vmac_bt_pkg::ST_DRAW: state_next = vmac_bt_pkg::ST_CHK_RAND;
            vmac_bt_pkg::ST_CHK_RAND: begin
                if (!in_range) begin
                    state_next = vmac_bt_pkg::ST_SCAN_MAC;
                end else if (phase_reg && id_hit) begin
                    // the last draw is taken even if its id is already in use
                    state_next = (draws_reg == CW'(vmac_bt_pkg::TableDepth + 1)) ?
                        vmac_bt_pkg::ST_SCAN_MAC : vmac_bt_pkg::ST_DRAW;
                end
            end
            vmac_bt_pkg::ST_SCAN_MAC: begin
                if (!in_range) begin
                    state_next = (op_reg == vmac_bt_pkg::OP_ADD) ?
                        vmac_bt_pkg::ST_SCAN_ID : vmac_bt_pkg::ST_DONE;
                end else if (phase_reg && mac_hit) begin
                    if (op_reg != vmac_bt_pkg::OP_ADD) begin
                        state_next = vmac_bt_pkg::ST_DONE;
                    end else if (id_hit) begin
                        state_next = vmac_bt_pkg::ST_DONE;
                    end else begin
                        state_next = vmac_bt_pkg::ST_REMOVE;
                    end
                end
            end
            vmac_bt_pkg::ST_SCAN_ID: begin
                if (!in_range) begin
                    state_next = (op_reg == vmac_bt_pkg::OP_ADD) ?
                        vmac_bt_pkg::ST_INS_POS : vmac_bt_pkg::ST_DONE;
                end else if (phase_reg && id_hit) begin
                    unique case (op_reg)
                        vmac_bt_pkg::OP_ADD:    state_next = vmac_bt_pkg::ST_WRITE;
                        vmac_bt_pkg::OP_DELETE: state_next = vmac_bt_pkg::ST_REMOVE;
                        default:                state_next = vmac_bt_pkg::ST_DONE;
                    endcase
                end
            end
            vmac_bt_pkg::ST_REMOVE: begin
                if (ptr_reg + 1'b1 >= count_reg) begin
                    state_next = (op_reg == vmac_bt_pkg::OP_ADD) ?
                        vmac_bt_pkg::ST_SCAN_ID : vmac_bt_pkg::ST_DONE;
                end
            end
            vmac_bt_pkg::ST_INS_POS: begin
                if (count_reg >= CW'(vmac_bt_pkg::TableDepth)) begin
                    state_next = vmac_bt_pkg::ST_DONE;
                end else if (!in_range || (phase_reg && !id_less)) begin
                    state_next = vmac_bt_pkg::ST_INS_SHIFT;
                end
            end
            vmac_bt_pkg::ST_INS_SHIFT: begin
                if (draws_reg <= ptr_reg) begin
                    state_next = vmac_bt_pkg::ST_WRITE;
                end
            end
            vmac_bt_pkg::ST_WRITE: state_next = vmac_bt_pkg::ST_DONE;
            vmac_bt_pkg::ST_READ: begin
                if (phase_reg) state_next = vmac_bt_pkg::ST_DONE;
            end
            vmac_bt_pkg::ST_DONE: state_next = vmac_bt_pkg::ST_IDLE;
            default: state_next = vmac_bt_pkg::ST_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        we    = 1'b0;
        waddr = ptr_reg[AW-1:0];
        wdata = '{id: id_reg, mac: mac_reg, ep: ep_reg};
        raddr = ptr_reg[AW-1:0];
        unique case (state_reg)
            vmac_bt_pkg::ST_REMOVE: begin
                // phase 0 reads ptr+1, phase 1 writes it into ptr
                raddr = AW'(ptr_reg + 1'b1);
                we    = phase_reg;
                wdata = rdata;
            end
            vmac_bt_pkg::ST_INS_SHIFT: begin
                // draws_reg walks down from count; copy slot k-1 into k
                raddr = AW'(draws_reg - 1'b1);
                waddr = draws_reg[AW-1:0];
                we    = phase_reg && (draws_reg > ptr_reg);
                wdata = rdata;
            end
            vmac_bt_pkg::ST_WRITE: we = 1'b1;
            vmac_bt_pkg::ST_READ: raddr = idx_reg;
            default: ;
        endcase
    end

    // pointer stepping for scans
    always_comb begin
        ptr_next = ptr_reg;
        if (phase_reg) ptr_next = ptr_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= vmac_bt_pkg::ST_IDLE;
            count_reg    <= '0;
            rnd_reg      <= 22'd1;
            mval_reg     <= 1'b0;
            phase_reg    <= 1'b0;
            ptr_reg      <= '0;
            draws_reg    <= '0;
            ok_reg       <= 1'b0;
            ins_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                rnd_reg <= (cfg_wdata == '0) ? 22'd1 : cfg_wdata;
            end
            if (mval_reg && m_ready) mval_reg <= 1'b0;

            unique case (state_reg)
                vmac_bt_pkg::ST_IDLE: begin
                    phase_reg <= 1'b0;
                    ptr_reg   <= '0;
                    draws_reg <= '0;
                    ok_reg    <= 1'b0;
                    ins_reg   <= 1'b0;
                    hold_reg  <= '0;
                    if (s_valid && s_ready) begin
                        op_reg  <= s_opcode;
                        id_reg  <= s_device_id;
                        mac_reg <= s_mac;
                        ep_reg  <= s_endpoint;
                        idx_reg <= s_index;
                    end
                end
                vmac_bt_pkg::ST_DRAW: begin
                    rnd_reg   <= vmac_bt_pkg::lfsr_step(rnd_reg);
                    id_reg    <= {1'b1, vmac_bt_pkg::lfsr_step(rnd_reg)};
                    draws_reg <= draws_reg + 1'b1;
                    ptr_reg   <= '0;
                    phase_reg <= 1'b0;
                end
                vmac_bt_pkg::ST_CHK_RAND: begin
                    if (in_range && !(phase_reg && id_hit)) begin
                        phase_reg <= ~phase_reg;
                        ptr_reg   <= ptr_next;
                    end else begin
                        ptr_reg   <= '0;
                        phase_reg <= 1'b0;
                    end
                end
                vmac_bt_pkg::ST_SCAN_MAC: begin
                    if (!in_range) begin
                        ptr_reg   <= '0;
                        phase_reg <= 1'b0;
                    end else if (phase_reg && mac_hit) begin
                        hold_reg  <= rdata;
                        ok_reg    <= 1'b1;
                        phase_reg <= 1'b0;
                        ptr_reg   <= ptr_reg;
                    end else begin
                        phase_reg <= ~phase_reg;
                        ptr_reg   <= ptr_next;
                    end
                end
                vmac_bt_pkg::ST_SCAN_ID: begin
                    if (!in_range) begin
                        ptr_reg   <= '0;
                        phase_reg <= 1'b0;
                    end else if (phase_reg && id_hit) begin
                        hold_reg  <= rdata;
                        ok_reg    <= 1'b1;
                        phase_reg <= 1'b0;
                    end else begin
                        phase_reg <= ~phase_reg;
                        ptr_reg   <= ptr_next;
                    end
                end
                vmac_bt_pkg::ST_REMOVE: begin
                    if (ptr_reg + 1'b1 >= count_reg) begin
                        count_reg <= count_reg - 1'b1;
                        ptr_reg   <= '0;
                        phase_reg <= 1'b0;
                        if (op_reg == vmac_bt_pkg::OP_ADD) ok_reg <= 1'b0;
                    end else begin
                        phase_reg <= ~phase_reg;
                        ptr_reg   <= ptr_next;
                    end
                end
                vmac_bt_pkg::ST_INS_POS: begin
                    if (count_reg >= CW'(vmac_bt_pkg::TableDepth)) begin
                        ok_reg <= 1'b0;
                    end else if (!in_range || (phase_reg && !id_less)) begin
                        draws_reg <= count_reg;
                        phase_reg <= 1'b0;
                        ins_reg   <= 1'b1;
                    end else begin
                        phase_reg <= ~phase_reg;
                        ptr_reg   <= ptr_next;
                    end
                end
                vmac_bt_pkg::ST_INS_SHIFT: begin
                    if (draws_reg > ptr_reg) begin
                        phase_reg <= ~phase_reg;
                        if (phase_reg) draws_reg <= draws_reg - 1'b1;
                    end
                end
                vmac_bt_pkg::ST_WRITE: begin
                    ok_reg <= 1'b1;
                    if (ins_reg) count_reg <= count_reg + 1'b1;
                end
                vmac_bt_pkg::ST_READ: begin
                    phase_reg <= 1'b1;
                    if (phase_reg) begin
                        hold_reg <= rdata;
                        ok_reg   <= ({1'b0, idx_reg} < count_reg);
                    end
                end
                vmac_bt_pkg::ST_DONE: begin
                    mval_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // result register
    logic res_ok;
    always_comb begin
        res_ok = ok_reg;
        if (op_reg == vmac_bt_pkg::OP_ADD) begin
            // add: ok as left by the scans; same pair under same id is success with no change
            res_ok = ok_reg;
        end else if (op_reg > vmac_bt_pkg::OP_READ) begin
            res_ok = 1'b0;
        end
    end

    logic res_ok_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == vmac_bt_pkg::ST_DONE) begin
            res_ok_reg <= res_ok;
            if (op_reg == vmac_bt_pkg::OP_ADD) begin
                res_reg <= '{id: id_reg, mac: mac_reg, ep: ep_reg};
            end else if (res_ok) begin
                res_reg <= hold_reg;
            end else begin
                res_reg <= '0;
            end
        end
    end

    assign m_valid          = mval_reg;
    assign m_ok             = res_ok_reg;
    assign m_found_id       = res_reg.id;
    assign m_found_mac      = res_reg.mac;
    assign m_found_endpoint = res_reg.ep;
    assign m_entries_used   = count_reg;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic        ok;
        logic [22:0] id;
        logic [63:0] mac;
        logic [7:0]  ep;
        logic [6:0]  used;
    } binding_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [21:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_opcode;
    logic [22:0] s_device_id;
    logic [63:0] s_mac;
    logic [7:0]  s_endpoint;
    logic [5:0]  s_index;
    logic        m_valid;
    logic        m_ready;
    logic        m_ok;
    logic [22:0] m_found_id;
    logic [63:0] m_found_mac;
    logic [7:0]  m_found_endpoint;
    logic [6:0]  m_entries_used;

    vmac_binding_table_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_device_id      (s_device_id),
        .s_mac            (s_mac),
        .s_endpoint       (s_endpoint),
        .s_index          (s_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ok             (m_ok),
        .m_found_id       (m_found_id),
        .m_found_mac      (m_found_mac),
        .m_found_endpoint (m_found_endpoint),
        .m_entries_used   (m_entries_used)
    );

    // shadow copy of the table
    logic [22:0]     tbl_id [vmac_bt_pkg::TableDepth];
    logic [63:0]     tbl_mac [vmac_bt_pkg::TableDepth];
    logic [7:0]      tbl_ep [vmac_bt_pkg::TableDepth];
    int              tbl_count;
    logic [21:0]     rand_state;
    binding_result_t pending_results[$];
    int              fail_count;
    longint          cycle_count;
    bit              quiet_mode;

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 64'd30000000) begin
            $display("timeout at %0t", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int slot_of_id(input logic [22:0] id);
        for (int k = 0; k < tbl_count; k++)
            if (tbl_id[k] == id) return k;
        return -1;
    endfunction

    function automatic int slot_of_mac(input logic [63:0] mac, input logic [7:0] ep);
        for (int k = 0; k < tbl_count; k++)
            if (tbl_mac[k] == mac && tbl_ep[k] == ep) return k;
        return -1;
    endfunction

    function automatic void drop_slot(input int s);
        for (int k = s; k + 1 < tbl_count; k++) begin
            tbl_id[k]  = tbl_id[k+1];
            tbl_mac[k] = tbl_mac[k+1];
            tbl_ep[k]  = tbl_ep[k+1];
        end
        tbl_count--;
    endfunction

    function automatic logic [22:0] next_random_id();
        rand_state = {rand_state[20:0], rand_state[21] ^ rand_state[20]};
        return {1'b1, rand_state};
    endfunction

    // predict the result of one operation and update the shadow table
    function automatic binding_result_t predict_binding(input logic [2:0] op,
            input logic [22:0] id, input logic [63:0] mac, input logic [7:0] ep,
            input logic [5:0] idx);
        binding_result_t r;
        int s;
        int pos;
        r = '{1'b0, '0, '0, '0, '0};
        case (op)
            vmac_bt_pkg::OP_ADD: begin
                if (id == vmac_bt_pkg::RandomId) begin
                    id = next_random_id();
                    for (int n = 0; n < vmac_bt_pkg::TableDepth && slot_of_id(id) >= 0; n++)
                        id = next_random_id();
                end
                s = slot_of_mac(mac, ep);
                if (s >= 0 && tbl_id[s] == id) begin
                    r.ok = 1'b1;
                end else begin
                    if (s >= 0) drop_slot(s);
                    s = slot_of_id(id);
                    if (s >= 0) begin
                        tbl_mac[s] = mac;
                        tbl_ep[s]  = ep;
                        r.ok = 1'b1;
                    end else if (tbl_count < vmac_bt_pkg::TableDepth) begin
                        pos = 0;
                        while (pos < tbl_count && tbl_id[pos] < id) pos++;
                        for (int k = tbl_count; k > pos; k--) begin
                            tbl_id[k]  = tbl_id[k-1];
                            tbl_mac[k] = tbl_mac[k-1];
                            tbl_ep[k]  = tbl_ep[k-1];
                        end
                        tbl_id[pos]  = id;
                        tbl_mac[pos] = mac;
                        tbl_ep[pos]  = ep;
                        tbl_count++;
                        r.ok = 1'b1;
                    end
                end
                r.id  = id;
                r.mac = mac;
                r.ep  = ep;
            end
            vmac_bt_pkg::OP_DELETE, vmac_bt_pkg::OP_LK_ID: begin
                s = slot_of_id(id);
                if (s >= 0) begin
                    r = '{1'b1, tbl_id[s], tbl_mac[s], tbl_ep[s], '0};
                    if (op == vmac_bt_pkg::OP_DELETE) drop_slot(s);
                end
            end
            vmac_bt_pkg::OP_LK_MAC: begin
                s = slot_of_mac(mac, ep);
                if (s >= 0) r = '{1'b1, tbl_id[s], tbl_mac[s], tbl_ep[s], '0};
            end
            vmac_bt_pkg::OP_READ: begin
                if (idx < tbl_count) r = '{1'b1, tbl_id[idx], tbl_mac[idx], tbl_ep[idx], '0};
            end
            default: ;
        endcase
        r.used = tbl_count[6:0];
        return r;
    endfunction

    // result checker with random stall
    always @(posedge aclk) begin
        binding_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer", $time);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_ok !== exp_r.ok) begin
                    $display("%0t: ok exp %0d got %0d", $time, exp_r.ok, m_ok);
                    fail_count++;
                end
                if (m_found_id !== exp_r.id) begin
                    $display("%0t: id exp %0h got %0h", $time, exp_r.id, m_found_id);
                    fail_count++;
                end
                if (m_found_mac !== exp_r.mac) begin
                    $display("%0t: mac exp %0h got %0h", $time, exp_r.mac, m_found_mac);
                    fail_count++;
                end
                if (m_found_endpoint !== exp_r.ep) begin
                    $display("%0t: ep exp %0h got %0h", $time, exp_r.ep, m_found_endpoint);
                    fail_count++;
                end
                if (m_entries_used !== exp_r.used) begin
                    $display("%0t: used exp %0d got %0d", $time, exp_r.used, m_entries_used);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 11);
    end

    // send one operation, with random idle before it
    task automatic send_op(input logic [2:0] op, input logic [22:0] id,
            input logic [63:0] mac, input logic [7:0] ep, input logic [5:0] idx);
        @(negedge aclk);
        while (!quiet_mode && $urandom_range(99) < 11) @(negedge aclk);
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_device_id <= id;
        s_mac       <= mac;
        s_endpoint  <= ep;
        s_index     <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_binding(op, id, mac, ep, idx));
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_seed(input logic [21:0] seed);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= seed;
        @(negedge aclk);
        cfg_we <= 1'b0;
        rand_state = (seed == 0) ? 22'd1 : seed;
    endtask

    function automatic logic [63:0] rand_mac();
        return {$urandom, $urandom};
    endfunction

    // small table: empty read and delete, repeated and rebound adds, lookups, reads, bad opcodes, random add, deletes
    task automatic test_extremes();
        send_op(vmac_bt_pkg::OP_READ, '0, '0, '0, 6'd0);
        send_op(vmac_bt_pkg::OP_DELETE, 23'd5, '0, '0, '0);
        send_op(vmac_bt_pkg::OP_ADD, 23'd0, 64'd0, 8'd0, '0);
        send_op(vmac_bt_pkg::OP_ADD, 23'h7FFFFF, '1, 8'hFF, '0);
        send_op(vmac_bt_pkg::OP_ADD, 23'h7FFFFF, '1, 8'hFF, '0);
        send_op(vmac_bt_pkg::OP_ADD, 23'd10, '1, 8'hFF, '0);
        send_op(vmac_bt_pkg::OP_ADD, 23'd10, 64'h1234, 8'h01, '0);
        send_op(vmac_bt_pkg::OP_LK_MAC, '0, 64'h1234, 8'h01, '0);
        send_op(vmac_bt_pkg::OP_LK_MAC, '0, 64'h1234, 8'h02, '0);
        send_op(vmac_bt_pkg::OP_LK_ID, 23'd0, '0, '0, '0);
        send_op(vmac_bt_pkg::OP_READ, '0, '0, '0, 6'd1);
        send_op(vmac_bt_pkg::OP_READ, '0, '0, '0, 6'd63);
        send_op(3'd5, 23'd10, '0, '0, '0);
        send_op(3'd7, 23'd10, '0, '0, '0);
        send_op(vmac_bt_pkg::OP_ADD, vmac_bt_pkg::RandomId, 64'hAA, 8'd3, '0);
        send_op(vmac_bt_pkg::OP_DELETE, 23'd10, '0, '0, '0);
        send_op(vmac_bt_pkg::OP_DELETE, 23'd0, '0, '0, '0);
    endtask

    task automatic test_full_table();
        for (int k = 0; k < vmac_bt_pkg::TableDepth + 2; k++)
            send_op(vmac_bt_pkg::OP_ADD,
                    (k % 3 == 0) ? vmac_bt_pkg::RandomId : 23'($urandom), rand_mac(),
                    8'($urandom), '0);
        send_op(vmac_bt_pkg::OP_READ, '0, '0, '0, 6'd63);
        // rebind an existing pair under a new id while full
        send_op(vmac_bt_pkg::OP_ADD, 23'd77, tbl_mac[5], tbl_ep[5], '0);
        for (int k = 0; k < vmac_bt_pkg::TableDepth; k++)
            send_op(vmac_bt_pkg::OP_DELETE, tbl_id[0], '0, '0, '0);
    endtask

    // random operations over a small id and mac pool
    task automatic test_random(input int n);
        logic [2:0]  op;
        logic [22:0] id;
        logic [63:0] mac;
        for (int k = 0; k < n; k++) begin
            op = ($urandom_range(9) < 4) ? vmac_bt_pkg::OP_ADD : 3'($urandom_range(7));
            id = ($urandom_range(3) == 0) ? 23'($urandom) : 23'($urandom_range(40));
            if (op == vmac_bt_pkg::OP_ADD && $urandom_range(7) == 0)
                id = vmac_bt_pkg::RandomId;
            if (op != vmac_bt_pkg::OP_ADD && tbl_count > 0 && $urandom_range(1))
                id = tbl_id[$urandom_range(tbl_count - 1)];
            mac = ($urandom_range(3) == 0) ? rand_mac() : 64'($urandom_range(30));
            send_op(op, id, mac, 8'($urandom_range(3)), 6'($urandom));
            if (k == n / 2) wait_drained();
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_opcode    = '0;
        s_device_id = '0;
        s_mac       = '0;
        s_endpoint  = '0;
        s_index     = '0;
        m_ready     = 1'b0;
        fail_count  = 0;
        cycle_count = 0;
        quiet_mode  = 1'b0;
        tbl_count   = 0;
        rand_state  = 22'd1;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_extremes();
        test_full_table();
        write_seed(22'h3FFFFF);
        test_random(100);
        write_seed(22'd0);
        quiet_mode = 1'b1;
        test_random(80);
        quiet_mode = 1'b0;
        write_seed(22'($urandom_range(22'h3FFFFF, 1)));
        test_random(90);
        write_seed(22'd1);
        test_random(80);
        wait_drained();

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
